// File: hw/rtl/blae_pkg.sv
// ----------------------------------------------------------------------------
// blae_pkg
// Shared constants and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package blae_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned POS_W = 9;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/blae_in_if.sv
// ----------------------------------------------------------------------------
// blae_in_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface blae_in_if;
  import blae_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input item_value,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/blae_out_if.sv
// ----------------------------------------------------------------------------
// blae_out_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface blae_out_if;
  import blae_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic             match_found;
  logic [IDX_W-1:0] match_index;
  logic [CNT_W-1:0] count_after;

  modport source (output valid, output status, output match_found,
                  output match_index, output count_after, input ready);
  modport sink   (input valid, input status, input match_found,
                  input match_index, input count_after, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/blae_ram.sv
// ----------------------------------------------------------------------------
// blae_ram
// Simple dual-port list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module blae_ram #(
  parameter int unsigned DEPTH = blae_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [blae_pkg::VAL_W-1:0] wdata,
  input  wire logic                              re,
  input  wire logic [AW-1:0]                     raddr,
  output logic signed [blae_pkg::VAL_W-1:0]      rdata
);
  import blae_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Fixed-capacity ordered list of signed words held in one synchronous RAM.
// Push/pop back and clear finish without moving entries.
// Insert/push front shift the entries from position up by one; erase/pop front
// shift the entries after position down; no entry moves when position is the
// list's end. Find scans from index 0 to the first match or the last entry.
// One item in work at a time; the next is taken while a result waits.
// Sync reset clears the count and the handshakes; list contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine #(
  parameter int unsigned DEPTH = blae_pkg::DEPTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  blae_in_if.sink    in_ch,
  blae_out_if.source out_ch
);
  import blae_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FIND,
    S_FINISH
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [AW-1:0]           rp;
  logic [AW-1:0]           wp;
  logic [AW-1:0]           lo;
  logic [AW-1:0]           stop;
  logic                    dir_up;
  logic                    pend;
  logic                    rd_done;
  logic signed [VAL_W-1:0] key;
  status_t                 st;
  logic                    found;
  logic [AW-1:0]           idx;

  logic                    ovalid;
  status_t                 ostatus;
  logic                    ofound;
  logic [AW-1:0]           oidx;
  logic [CW-1:0]           ocount;

  cmd_t                    cmd;
  logic [XW-1:0]           pos_x;
  logic [XW-1:0]           cnt_x;
  logic [AW-1:0]           p_addr;
  logic [AW-1:0]           cnt_addr;
  logic                    is_full;
  logic                    is_empty;
  logic                    ins_ok;
  logic                    in_fire;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    re;
  logic signed [VAL_W-1:0] rd_data;

  blae_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rp),
    .rdata (rd_data)
  );

  assign in_ch.ready        = (state == S_IDLE);
  assign in_fire            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = ovalid;
  assign out_ch.status      = ostatus;
  assign out_ch.match_found = ofound;
  assign out_ch.match_index = IDX_W'(oidx);
  assign out_ch.count_after = CNT_W'(ocount);

  always_comb begin
    cmd      = cmd_t'(in_ch.cmd);
    pos_x    = XW'(in_ch.position);
    cnt_x    = XW'(count);
    cnt_addr = count[AW-1:0];
    p_addr   = (cmd == CMD_PUSH_FRONT || cmd == CMD_POP_FRONT) ? '0 : AW'(in_ch.position);
    is_full  = (count == CW'(DEPTH));
    is_empty = (count == '0);
    ins_ok   = !is_full && (cmd == CMD_PUSH_FRONT || (cmd == CMD_INSERT && pos_x <= cnt_x));
    re       = (state == S_SHIFT || state == S_FIND) && !rd_done;
  end

  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = rd_data;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_PUSH_BACK && !is_full) begin
            we    = 1'b1;
            waddr = cnt_addr;
            wdata = in_ch.item_value;
          end else if (ins_ok && p_addr == cnt_addr) begin
            we    = 1'b1;
            waddr = p_addr;
            wdata = in_ch.item_value;
          end
        end
      end
      S_SHIFT: begin
        if (pend) begin
          we = 1'b1;
        end else if (rd_done && dir_up) begin
          we    = 1'b1;
          waddr = lo;
          wdata = key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      rd_done <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      pend <= re;
      if (out_ch.valid && out_ch.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            st      <= ST_OK;
            found   <= 1'b0;
            idx     <= '0;
            key     <= in_ch.item_value;
            lo      <= p_addr;
            rd_done <= 1'b0;
            state   <= S_FINISH;
            unique case (cmd)
              CMD_PUSH_BACK: begin
                if (is_full) st <= ST_FULL;
                else count <= count + CW'(1);
              end
              CMD_POP_BACK: begin
                if (is_empty) st <= ST_EMPTY;
                else count <= count - CW'(1);
              end
              CMD_PUSH_FRONT, CMD_INSERT: begin
                if (is_full) begin
                  st <= ST_FULL;
                end else if (!ins_ok) begin
                  st <= ST_BADPOS;
                end else if (p_addr == cnt_addr) begin
                  count <= count + CW'(1);
                end else begin
                  state  <= S_SHIFT;
                  dir_up <= 1'b1;
                  rp     <= cnt_addr - AW'(1);
                  wp     <= cnt_addr;
                  stop   <= p_addr;
                end
              end
              CMD_POP_FRONT, CMD_ERASE: begin
                if (is_empty) begin
                  st <= ST_EMPTY;
                end else if (cmd == CMD_ERASE && pos_x >= cnt_x) begin
                  st <= ST_BADPOS;
                end else if (CW'(p_addr) + CW'(1) == count) begin
                  count <= count - CW'(1);
                end else begin
                  state  <= S_SHIFT;
                  dir_up <= 1'b0;
                  rp     <= p_addr + AW'(1);
                  wp     <= p_addr;
                  stop   <= AW'(count - CW'(1));
                end
              end
              CMD_FIND: begin
                if (!is_empty) begin
                  state <= S_FIND;
                  rp    <= '0;
                  wp    <= '0;
                  stop  <= AW'(count - CW'(1));
                end
              end
              CMD_CLEAR: begin
                count <= '0;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (re) begin
            if (rp == stop) rd_done <= 1'b1;
            else rp <= dir_up ? rp - AW'(1) : rp + AW'(1);
          end
          if (pend) begin
            wp <= dir_up ? wp - AW'(1) : wp + AW'(1);
          end else if (rd_done) begin
            count <= dir_up ? count + CW'(1) : count - CW'(1);
            state <= S_FINISH;
          end
        end
        S_FIND: begin
          if (re) begin
            if (rp == stop) rd_done <= 1'b1;
            else rp <= rp + AW'(1);
          end
          if (pend) begin
            if (rd_data == key) begin
              found <= 1'b1;
              idx   <= wp;
              state <= S_FINISH;
            end else if (wp == stop) begin
              state <= S_FINISH;
            end else begin
              wp <= wp + AW'(1);
            end
          end
        end
        S_FINISH: begin
          if (!ovalid || out_ch.ready) begin
            ovalid  <= 1'b1;
            ostatus <= st;
            ofound  <= found;
            oidx    <= idx;
            ocount  <= count;
            state   <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_fire && cmd == CMD_CLEAR |=> count == '0)
    else $error("clear did not empty the list");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    ovalid && ostatus == ST_FULL |-> ocount == CW'(DEPTH))
    else $error("full status with list not full");

  a_find_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_FIND |-> !we)
    else $error("write during find scan");

  a_hit_only_find: assert property (@(posedge clk) disable iff (rst)
    ovalid && ofound |-> ostatus == ST_OK)
    else $error("match flagged with error status");

endmodule

`default_nettype wire
